// ===== hdl/qmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared widths, register indexes and divider step for the quad motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

    // fixed point: 1.0 = 2^FRACTION_BITS
    localparam int FRACTION_BITS = 12;

    // field widths
    localparam int THR_W   = 13;
    localparam int CMD_W   = 14;
    localparam int MV_W    = 16;
    localparam int DRIVE_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // sum of four terms needs two extra bits over a command; MIX_W keeps three
    localparam int MIX_W   = CMD_W + 3;
    // a positive mix stays below 2^(MIX_W-2)
    localparam int MIXP_W  = MIX_W - 2;
    localparam int NUM_W   = MIXP_W + MV_W;
    localparam int PROD_W  = NUM_W + DRIVE_W;
    localparam int NQ_W    = PROD_W - FRACTION_BITS;
    localparam int DEN_W   = MV_W + FRACTION_BITS;

    localparam int NUM_LANES = 4;

    // divider: one quotient bit per step
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DRIVE_W / DIV_STEPS_PER_STAGE;

    // stage 0 mix, 1 multiply, 2 scale, then divider stages
    localparam int NUM_STAGES = 3 + DIV_STAGES;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_LAYOUT  = 2'd0,
        REG_SPIN_REVERSED = 2'd1,
        REG_REFERENCE_MV  = 2'd2
    } cfg_index_t;

    localparam logic [MV_W-1:0] REFERENCE_MV_RESET = 16'd10500;

    typedef struct packed {
        logic [MV_W-1:0] rem;
        logic            qbit;
    } div_step_t;

    // one restoring division step
    function automatic div_step_t div_step(input logic [MV_W-1:0] rem,
                                           input logic            nbit,
                                           input logic [MV_W-1:0] divisor);
        logic [MV_W:0] trial;
        logic [MV_W:0] diff;
        div_step_t     res;
        trial = {rem, nbit};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            res.rem  = diff[MV_W-1:0];
            res.qbit = 1'b1;
        end else begin
            res.rem  = trial[MV_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== hdl/qmm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmm_lane
// One motor lane: scales a mix by reference / supply and maps it to a byte.
// ----------------------------------------------------------------------------
module qmm_lane
    import qmm_pkg::*;
(
    input  logic                    aclk,
    input  stage_en_t               stage_en,
    input  logic signed [MIX_W-1:0] mix_in,
    input  logic [MV_W-1:0]         supply_in,
    input  logic [MV_W-1:0]         ref_mv,
    output logic [DRIVE_W-1:0]      drive
);

    // stage 1: mix times reference
    logic [NUM_W-1:0]  num_reg,    num_next;
    logic [MV_W-1:0]   sup1_reg;
    logic              pos1_reg,   pos1_next;

    always_comb begin
        pos1_next = !mix_in[MIX_W-1] && (mix_in != '0) && (ref_mv != '0);
        num_next  = NUM_W'(mix_in[MIXP_W-1:0]) * NUM_W'(ref_mv);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            num_reg  <= num_next;
            sup1_reg <= supply_in;
            pos1_reg <= pos1_next;
        end
    end

    // stage 2: times 255, drop the fraction, saturation check
    logic [PROD_W-1:0] prod;
    logic [NQ_W-1:0]   nq;
    logic [NUM_W-1:0]  den;
    logic              sat2_next;

    // divider pipeline, index 0 is stage 2
    logic [MV_W-1:0]    rem_reg  [DIV_STAGES+1];
    logic [DRIVE_W-1:0] low_reg  [DIV_STAGES+1];
    logic [DRIVE_W-1:0] q_reg    [DIV_STAGES+1];
    logic [MV_W-1:0]    sup_reg  [DIV_STAGES+1];
    logic               pos_reg  [DIV_STAGES+1];
    logic               sat_reg  [DIV_STAGES+1];

    always_comb begin
        prod      = {num_reg, {DRIVE_W{1'b0}}} - {{DRIVE_W{1'b0}}, num_reg};
        nq        = prod[PROD_W-1:FRACTION_BITS];
        den       = NUM_W'({sup1_reg, {FRACTION_BITS{1'b0}}});
        sat2_next = (num_reg >= den);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            rem_reg[0] <= nq[DRIVE_W+MV_W-1:DRIVE_W];
            low_reg[0] <= nq[DRIVE_W-1:0];
            q_reg[0]   <= '0;
            sup_reg[0] <= sup1_reg;
            pos_reg[0] <= pos1_reg;
            sat_reg[0] <= sat2_next;
        end
    end

    // divider stages, DIV_STEPS_PER_STAGE quotient bits each
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [MV_W-1:0]    rem_next;
        logic [DRIVE_W-1:0] low_next;
        logic [DRIVE_W-1:0] q_next;
        div_step_t          st;

        always_comb begin
            rem_next = rem_reg[j];
            low_next = low_reg[j];
            q_next   = q_reg[j];
            st       = '0;
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
                st       = div_step(rem_next, low_next[DRIVE_W-1], sup_reg[j]);
                rem_next = st.rem;
                low_next = {low_next[DRIVE_W-2:0], 1'b0};
                q_next   = {q_next[DRIVE_W-2:0], st.qbit};
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[3+j]) begin
                rem_reg[j+1] <= rem_next;
                low_reg[j+1] <= low_next;
                q_reg[j+1]   <= q_next;
                sup_reg[j+1] <= sup_reg[j];
                pos_reg[j+1] <= pos_reg[j];
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    // final byte: zero for a non-positive mix or a zero reference, full scale on saturation
    always_comb begin
        if (!pos_reg[DIV_STAGES]) begin
            drive = '0;
        end else if (sat_reg[DIV_STAGES]) begin
            drive = '1;
        end else begin
            drive = q_reg[DIV_STAGES];
        end
    end

endmodule

// ===== hdl/quad_motor_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_motor_mixer
// Mixes throttle, roll, pitch and yaw into four supply-compensated drive bytes.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_ channel carries throttle, roll, pitch, yaw (1.0 = 4096)
//   and the measured supply in mV. The m_ channel returns one result per
//   request with four drive bytes in motor order.
//   Configuration (frame layout, spin direction, reference mV) is written via
//   cfg_wr_en / cfg_index / cfg_wdata while no request is in flight.
// Pipeline and throughput:
//   Seven pipeline stages: mix, multiply by the reference, scale by 255,
//   then four divider stages producing two quotient bits each. A request
//   passes through the stage registers in that order to m_valid; one request
//   per cycle is taken while m_ready does not stall the output.
// Reset:
//   aresetn low clears all stage valid bits and loads the register defaults
//   (X frame, normal spin, 10500 mV reference).
// Stall:
//   Each stage advances when it is empty or the next stage moves, so bubbles
//   are squeezed out and s_ready drops only once the whole pipeline is full.
// ----------------------------------------------------------------------------
module quad_motor_mixer
    import qmm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [THR_W-1:0]        s_throttle_cmd,
    input  logic signed [CMD_W-1:0] s_roll_cmd,
    input  logic signed [CMD_W-1:0] s_pitch_cmd,
    input  logic signed [CMD_W-1:0] s_yaw_cmd,
    input  logic [MV_W-1:0]         s_supply_mv,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DRIVE_W-1:0]      m_drive_0,
    output logic [DRIVE_W-1:0]      m_drive_1,
    output logic [DRIVE_W-1:0]      m_drive_2,
    output logic [DRIVE_W-1:0]      m_drive_3
);

    // configuration registers
    logic            frame_layout_reg;
    logic            spin_reversed_reg;
    logic [MV_W-1:0] reference_mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_layout_reg  <= 1'b0;
            spin_reversed_reg <= 1'b0;
            reference_mv_reg  <= REFERENCE_MV_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_FRAME_LAYOUT:  frame_layout_reg  <= cfg_wdata[0];
                REG_SPIN_REVERSED: spin_reversed_reg <= cfg_wdata[0];
                REG_REFERENCE_MV:  reference_mv_reg  <= cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage advance
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    stage_en_t             stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // stage 0: sign matrix
    logic signed [MIX_W-1:0] t_s, r_s, p_s, y_s;
    logic signed [MIX_W-1:0] mix_next [NUM_LANES];
    logic signed [MIX_W-1:0] mix_reg  [NUM_LANES];
    logic [MV_W-1:0]         supply_reg;

    always_comb begin
        t_s = MIX_W'(s_throttle_cmd);
        r_s = MIX_W'(s_roll_cmd);
        p_s = MIX_W'(s_pitch_cmd);
        y_s = spin_reversed_reg ? -MIX_W'(s_yaw_cmd) : MIX_W'(s_yaw_cmd);
        if (!frame_layout_reg) begin
            mix_next[0] = t_s + r_s + p_s - y_s;
            mix_next[1] = t_s + r_s - p_s + y_s;
            mix_next[2] = t_s - r_s + p_s + y_s;
            mix_next[3] = t_s - r_s - p_s - y_s;
        end else begin
            mix_next[0] = t_s + p_s - y_s;
            mix_next[1] = t_s + r_s + y_s;
            mix_next[2] = t_s - r_s + y_s;
            mix_next[3] = t_s - p_s - y_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mix_reg    <= mix_next;
            supply_reg <= s_supply_mv;
        end
    end

    // scaling and conversion lanes
    logic [DRIVE_W-1:0] drive [NUM_LANES];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        qmm_lane u_lane (
            .aclk      (aclk),
            .stage_en  (stage_en),
            .mix_in    (mix_reg[i]),
            .supply_in (supply_reg),
            .ref_mv    (reference_mv_reg),
            .drive     (drive[i])
        );
    end

    assign m_drive_0 = drive[0];
    assign m_drive_1 = drive[1];
    assign m_drive_2 = drive[2];
    assign m_drive_3 = drive[3];

endmodule
